@@ hw/rtl/gme_pkg.sv @@
// ----------------------------------------------------------------------------
// gme_pkg
// Shared constants for the genotype marginal entropy pipeline.
// ----------------------------------------------------------------------------
package gme_pkg;

  localparam int TOTAL_BITS     = 27;
  localparam int NUM_CLASSES    = 4;
  localparam int CLASS_W        = 2;
  localparam int DEF_COUNT_BITS = 24;
  localparam int DEF_FRAC_BITS  = 16;

  // log2 unit: Q.30 working format
  localparam int WORK_FRAC = 30;
  localparam int LOG_E_W   = $clog2(TOTAL_BITS);
  localparam int LOG_W     = LOG_E_W + WORK_FRAC;
  localparam int LOG_LAT   = WORK_FRAC + 2;

  // ln(2) in Q.30
  localparam logic [WORK_FRAC-1:0] LN2_Q30 = 30'd744261118;

  // -p ln p term unit
  localparam int DIVQ_W    = 32;
  localparam int TERM_W    = 32;
  localparam int ACC_W     = 36;
  localparam int PLOGP_LAT = LOG_LAT + 3 + DIVQ_W + 2;

  localparam logic [CLASS_W-1:0] FIRST_CLASS = 2'd0;
  localparam logic [CLASS_W-1:0] LAST_CLASS  = CLASS_W'(NUM_CLASSES - 1);

endpackage

@@ hw/rtl/gme_delay.sv @@
// ----------------------------------------------------------------------------
// gme_delay
// Enabled shift line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module gme_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] tap [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign dout = tap[DEPTH-1];

endmodule

@@ hw/rtl/gme_div_pipe.sv @@
// ----------------------------------------------------------------------------
// gme_div_pipe
// Restoring divider, one quotient bit per stage. Dividend over divisor must
// stay below 2^QUO_W for the quotient to be exact.
// ----------------------------------------------------------------------------
module gme_div_pipe #(
  parameter int DEN_W = 27,
  parameter int QUO_W = 32
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [DEN_W+QUO_W-1:0] num,
  input  logic [DEN_W-1:0]       den,
  output logic [QUO_W-1:0]       quo
);

  // returns {remainder, shifted dividend/quotient word}
  function automatic logic [DEN_W+QUO_W-1:0] div_step(
    input logic [DEN_W-1:0] r,
    input logic [QUO_W-1:0] w,
    input logic [DEN_W-1:0] d
  );
    logic [DEN_W:0] r2;
    logic [DEN_W:0] diff;
    logic           ge;
    r2   = {r, w[QUO_W-1]};
    diff = r2 - {1'b0, d};
    ge   = (r2 >= {1'b0, d});
    return {(ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0]), w[QUO_W-2:0], ge};
  endfunction

  logic [DEN_W-1:0]       rem [QUO_W];
  logic [QUO_W-1:0]       wq  [QUO_W];
  logic [DEN_W-1:0]       dv  [QUO_W];
  logic [DEN_W+QUO_W-1:0] nx  [QUO_W];

  always_comb begin
    nx[0] = div_step(num[DEN_W+QUO_W-1:QUO_W], num[QUO_W-1:0], den);
    for (int i = 1; i < QUO_W; i++) begin
      nx[i] = div_step(rem[i-1], wq[i-1], dv[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0] <= den;
      for (int i = 1; i < QUO_W; i++) begin
        dv[i] <= dv[i-1];
      end
      for (int i = 0; i < QUO_W; i++) begin
        rem[i] <= nx[i][DEN_W+QUO_W-1:QUO_W];
        wq[i]  <= nx[i][QUO_W-1:0];
      end
    end
  end

  assign quo = wq[QUO_W-1];

endmodule

@@ hw/rtl/gme_frac.sv @@
// ----------------------------------------------------------------------------
// gme_frac
// Rounded fraction num/den in Q(FRAC_BITS); 0 on zero operand, 1.0 when
// num >= den.
// ----------------------------------------------------------------------------
module gme_frac #(
  parameter int COUNT_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [COUNT_BITS:0]   num,
  input  logic [COUNT_BITS+1:0] den,
  output logic [FRAC_BITS:0]    frac
);

  localparam int DEN_W = COUNT_BITS + 2;
  localparam int QB    = FRAC_BITS + 1;
  localparam logic [QB-1:0] FRAC_ONE = QB'(1) << FRAC_BITS;

  logic [DEN_W+QB-1:0] dvd;
  logic [QB-1:0]       quo;
  logic [1:0]          flags;
  logic [1:0]          flags_d;

  // add half the divisor for round to nearest
  assign dvd = ((DEN_W+QB)'(num) << FRAC_BITS) + (DEN_W+QB)'(den[DEN_W-1:1]);

  assign flags = {(num == '0) || (den == '0), DEN_W'(num) >= den};

  gme_div_pipe #(
    .DEN_W(DEN_W),
    .QUO_W(QB)
  ) u_div (
    .clk(clk),
    .en (en),
    .num(dvd),
    .den(den),
    .quo(quo)
  );

  gme_delay #(
    .WIDTH(2),
    .DEPTH(QB)
  ) u_flags (
    .clk (clk),
    .en  (en),
    .din (flags),
    .dout(flags_d)
  );

  assign frac = flags_d[1] ? '0 : (flags_d[0] ? FRAC_ONE : quo);

endmodule

@@ hw/rtl/gme_log2.sv @@
// ----------------------------------------------------------------------------
// gme_log2
// log2(x) in Q.30: normalize in two stages, then one squaring per stage.
// ----------------------------------------------------------------------------
module gme_log2 (
  input  logic                          clk,
  input  logic                          en,
  input  logic [gme_pkg::TOTAL_BITS-1:0] x,
  output logic [gme_pkg::LOG_W-1:0]      lg
);

  import gme_pkg::*;

  function automatic logic [LOG_E_W-1:0] msb_index(input logic [TOTAL_BITS-1:0] v);
    logic [LOG_E_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < TOTAL_BITS; i++) begin
      if (v[i]) idx = LOG_E_W'(i);
    end
    return idx;
  endfunction

  // returns {next mantissa, result bit}
  function automatic logic [WORK_FRAC+1:0] sq_step(input logic [WORK_FRAC:0] m);
    logic [2*WORK_FRAC+1:0] p;
    logic [WORK_FRAC+1:0]   s;
    p = m * m;
    s = p[2*WORK_FRAC+1:WORK_FRAC];
    if (s[WORK_FRAC+1]) return {s[WORK_FRAC+1:1], 1'b1};
    else return {s[WORK_FRAC:0], 1'b0};
  endfunction

  logic [TOTAL_BITS-1:0] xa;
  logic [LOG_E_W-1:0]    ea;
  logic [WORK_FRAC:0]    mb;
  logic [LOG_E_W-1:0]    eb;
  logic [WORK_FRAC:0]    ms [WORK_FRAC];
  logic [WORK_FRAC-1:0]  fs [WORK_FRAC];
  logic [LOG_E_W-1:0]    es [WORK_FRAC];
  logic [WORK_FRAC+1:0]  nx [WORK_FRAC];

  always_comb begin
    nx[0] = sq_step(mb);
    for (int i = 1; i < WORK_FRAC; i++) begin
      nx[i] = sq_step(ms[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xa <= x;
      ea <= msb_index(x);
      mb <= (WORK_FRAC+1)'(xa) << (LOG_E_W'(WORK_FRAC) - ea);
      eb <= ea;
      ms[0] <= nx[0][WORK_FRAC+1:1];
      fs[0] <= {(WORK_FRAC-1)'(0), nx[0][0]};
      es[0] <= eb;
      for (int i = 1; i < WORK_FRAC; i++) begin
        ms[i] <= nx[i][WORK_FRAC+1:1];
        fs[i] <= {fs[i-1][WORK_FRAC-2:0], nx[i][0]};
        es[i] <= es[i-1];
      end
    end
  end

  assign lg = {es[WORK_FRAC-1], fs[WORK_FRAC-1]};

endmodule

@@ hw/rtl/gme_plogp.sv @@
// ----------------------------------------------------------------------------
// gme_plogp
// One entropy term -p ln p in Q.30 with p = c / n. log2(n) comes in from a
// shared unit, aligned with this unit's own log2(c).
// ----------------------------------------------------------------------------
module gme_plogp #(
  parameter int COUNT_BITS = 24
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [COUNT_BITS:0]            c,
  input  logic [gme_pkg::TOTAL_BITS-1:0] n,
  input  logic [gme_pkg::LOG_W-1:0]      ln,
  output logic [gme_pkg::TERM_W-1:0]     term
);

  import gme_pkg::*;

  localparam int C_W    = COUNT_BITS + 1;
  localparam int CMP_W  = (C_W > TOTAL_BITS) ? C_W : TOTAL_BITS;
  localparam int DSPLIT = 18;
  localparam int TSPLIT = DIVQ_W / 2;
  localparam int PROD_W = 2 * LOG_W;
  localparam int MUL_W  = DIVQ_W + WORK_FRAC;

  logic                  zero_in;
  logic                  zero_d;
  logic [TOTAL_BITS-1:0] cx;
  logic [LOG_W-1:0]      lc;
  logic [TOTAL_BITS-1:0] c_l;
  logic [TOTAL_BITS-1:0] n_l;
  logic [LOG_W-1:0]      d1;
  logic [TOTAL_BITS-1:0] c1;
  logic [TOTAL_BITS-1:0] n1;
  logic [TOTAL_BITS+DSPLIT-1:0]       pl;
  logic [TOTAL_BITS+LOG_W-DSPLIT-1:0] ph;
  logic [TOTAL_BITS-1:0] n2;
  logic [PROD_W-1:0]     prod_sum;
  logic [TOTAL_BITS+DIVQ_W-1:0] prod;
  logic [TOTAL_BITS-1:0] n3;
  logic [DIVQ_W-1:0]     t;
  logic [TSPLIT+WORK_FRAC-1:0]        ml;
  logic [DIVQ_W-TSPLIT+WORK_FRAC-1:0] mh;
  logic [MUL_W-1:0]      msum;

  // term is zero for an empty class, a zero total or a saturated probability
  assign zero_in = (c == '0) || (n == '0) || (CMP_W'(c) >= CMP_W'(n));
  assign cx      = TOTAL_BITS'(c);

  gme_log2 u_log_c (
    .clk(clk),
    .en (en),
    .x  (cx),
    .lg (lc)
  );

  gme_delay #(
    .WIDTH(2 * TOTAL_BITS),
    .DEPTH(LOG_LAT)
  ) u_cn_dly (
    .clk (clk),
    .en  (en),
    .din ({cx, n}),
    .dout({c_l, n_l})
  );

  gme_delay #(
    .WIDTH(1),
    .DEPTH(PLOGP_LAT - 1)
  ) u_zero_dly (
    .clk (clk),
    .en  (en),
    .din (zero_in),
    .dout(zero_d)
  );

  assign prod_sum = PROD_W'(pl) + (PROD_W'(ph) << DSPLIT);
  assign msum     = MUL_W'(ml) + (MUL_W'(mh) << TSPLIT);

  always_ff @(posedge clk) begin
    if (en) begin
      d1   <= ln - lc;
      c1   <= c_l;
      n1   <= n_l;
      pl   <= c1 * d1[DSPLIT-1:0];
      ph   <= c1 * d1[LOG_W-1:DSPLIT];
      n2   <= n1;
      prod <= prod_sum[TOTAL_BITS+DIVQ_W-1:0];
      n3   <= n2;
      ml   <= t[TSPLIT-1:0] * LN2_Q30;
      mh   <= t[DIVQ_W-1:TSPLIT] * LN2_Q30;
      term <= zero_d ? '0 : msum[WORK_FRAC +: TERM_W];
    end
  end

  gme_div_pipe #(
    .DEN_W(TOTAL_BITS),
    .QUO_W(DIVQ_W)
  ) u_div (
    .clk(clk),
    .en (en),
    .num(prod),
    .den(n3),
    .quo(t)
  );

endmodule

@@ hw/rtl/genotype_marginal_entropy.sv @@
// ----------------------------------------------------------------------------
// genotype_marginal_entropy
// Per-class margins, group fractions, margin shares and entropies from
// case/control genotype counts.
// ----------------------------------------------------------------------------
// Each accepted item produces four result beats, one per genotype class in
// class order, so the block takes a new item only as the last class of the
// held item issues: the held item is issued into the pipeline one class per
// cycle unless the output stalls. Each class beat runs through a fully
// pipelined datapath (restoring dividers at one quotient bit per stage, a
// squaring log2 unit at one bit per stage), a summing stage and the output
// register. The entropy fields are filled on the fourth beat only, which also
// carries last. A stalled output holds the whole pipeline; nothing is dropped.
module genotype_marginal_entropy #(
  parameter int COUNT_BITS = gme_pkg::DEF_COUNT_BITS,
  parameter int FRAC_BITS  = gme_pkg::DEF_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [COUNT_BITS-1:0]           case_hom_major,
  input  logic [COUNT_BITS-1:0]           case_het,
  input  logic [COUNT_BITS-1:0]           case_hom_minor,
  input  logic [COUNT_BITS-1:0]           case_missing,
  input  logic [COUNT_BITS-1:0]           ctrl_hom_major,
  input  logic [COUNT_BITS-1:0]           ctrl_het,
  input  logic [COUNT_BITS-1:0]           ctrl_hom_minor,
  input  logic [COUNT_BITS-1:0]           ctrl_missing,
  input  logic [gme_pkg::TOTAL_BITS-1:0]  total_individuals,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [gme_pkg::CLASS_W-1:0]     class_index,
  output logic [COUNT_BITS:0]             margin,
  output logic [FRAC_BITS:0]              pbc_case,
  output logic [FRAC_BITS:0]              pbc_control,
  output logic [FRAC_BITS:0]              pca_case,
  output logic [FRAC_BITS:0]              pca_control,
  output logic [FRAC_BITS+1:0]            entropy,
  output logic [FRAC_BITS+1:0]            joint_entropy,
  output logic                            total_mismatch,
  output logic                            last
);

  import gme_pkg::*;

  localparam int NSUM_W = COUNT_BITS + 2;
  localparam int SUM_W  = COUNT_BITS + 3;
  localparam int MIS_W  = (SUM_W > TOTAL_BITS) ? SUM_W : TOTAL_BITS;
  localparam int FW     = FRAC_BITS + 1;
  localparam int SB_W   = CLASS_W + 2 + COUNT_BITS + 1;
  localparam int T      = PLOGP_LAT;
  localparam int FR_DLY = T - FW;
  localparam int RSH    = WORK_FRAC - FRAC_BITS;
  localparam logic [ACC_W:0] RND = (ACC_W+1)'(1) << (RSH - 1);

  logic en;

  // held item
  logic                   held;
  logic [CLASS_W-1:0]     cnt;
  logic [COUNT_BITS-1:0]  hca [NUM_CLASSES];
  logic [COUNT_BITS-1:0]  hco [NUM_CLASSES];
  logic [NSUM_W-1:0]      hnc;
  logic [NSUM_W-1:0]      hnt;
  logic [TOTAL_BITS-1:0]  htot;

  // issue stage
  logic                   s0_valid;
  logic [CLASS_W-1:0]     s0_cls;
  logic                   s0_last;
  logic                   s0_mism;
  logic [COUNT_BITS-1:0]  s0_ca;
  logic [COUNT_BITS-1:0]  s0_co;
  logic [COUNT_BITS:0]    s0_mar;
  logic [NSUM_W-1:0]      s0_nc;
  logic [NSUM_W-1:0]      s0_nt;
  logic [TOTAL_BITS-1:0]  s0_n;

  logic [T:1]             vpipe;
  logic [LOG_W-1:0]       ln_n;
  logic [FW-1:0]          f_pbca, f_pbco, f_pcca, f_pcco;
  logic [4*FW-1:0]        fr_t;
  logic [TERM_W-1:0]      tm_mar, tm_ca, tm_co;
  logic [SB_W-1:0]        sb_t;
  logic [CLASS_W-1:0]     cls_t;
  logic                   last_t;
  logic                   mism_t;
  logic [COUNT_BITS:0]    mar_t;

  // stage T+1
  logic                   v1;
  logic [CLASS_W-1:0]     cls1;
  logic                   last1;
  logic                   mism1;
  logic [COUNT_BITS:0]    mar1;
  logic [4*FW-1:0]        fr1;
  logic [ACC_W-1:0]       h_acc;
  logic [ACC_W-1:0]       hy_acc;
  logic [ACC_W:0]         h_rnd;
  logic [ACC_W:0]         hy_rnd;

  assign en       = !out_valid || out_ready;
  assign in_ready = !held || (en && (cnt == LAST_CLASS));

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= 1'b0;
      cnt       <= FIRST_CLASS;
      s0_valid  <= 1'b0;
      vpipe     <= '0;
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        held <= 1'b1;
        cnt  <= FIRST_CLASS;
      end else if (en && held && (cnt == LAST_CLASS)) begin
        held <= 1'b0;
      end else if (en && held) begin
        cnt <= cnt + CLASS_W'(1);
      end
      if (en) begin
        s0_valid  <= held;
        vpipe     <= {vpipe[T-1:1], s0_valid};
        v1        <= vpipe[T];
        out_valid <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hca[0] <= case_hom_major;
      hca[1] <= case_het;
      hca[2] <= case_hom_minor;
      hca[3] <= case_missing;
      hco[0] <= ctrl_hom_major;
      hco[1] <= ctrl_het;
      hco[2] <= ctrl_hom_minor;
      hco[3] <= ctrl_missing;
      hnc    <= NSUM_W'(case_hom_major) + NSUM_W'(case_het)
              + NSUM_W'(case_hom_minor) + NSUM_W'(case_missing);
      hnt    <= NSUM_W'(ctrl_hom_major) + NSUM_W'(ctrl_het)
              + NSUM_W'(ctrl_hom_minor) + NSUM_W'(ctrl_missing);
      htot   <= total_individuals;
    end
    if (en) begin
      s0_cls  <= cnt;
      s0_last <= (cnt == LAST_CLASS);
      s0_ca   <= hca[cnt];
      s0_co   <= hco[cnt];
      s0_mar  <= (COUNT_BITS+1)'(hca[cnt]) + (COUNT_BITS+1)'(hco[cnt]);
      s0_nc   <= hnc;
      s0_nt   <= hnt;
      s0_n    <= htot;
      s0_mism <= (MIS_W'(hnc) + MIS_W'(hnt)) != MIS_W'(htot);
    end
  end

  // group fractions and margin shares
  gme_frac #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_pbc_case (
    .clk(clk), .en(en), .num((COUNT_BITS+1)'(s0_ca)), .den(s0_nc), .frac(f_pbca)
  );
  gme_frac #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_pbc_ctrl (
    .clk(clk), .en(en), .num((COUNT_BITS+1)'(s0_co)), .den(s0_nt), .frac(f_pbco)
  );
  gme_frac #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_pca_case (
    .clk(clk), .en(en), .num((COUNT_BITS+1)'(s0_ca)), .den(NSUM_W'(s0_mar)),
    .frac(f_pcca)
  );
  gme_frac #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_pca_ctrl (
    .clk(clk), .en(en), .num((COUNT_BITS+1)'(s0_co)), .den(NSUM_W'(s0_mar)),
    .frac(f_pcco)
  );

  gme_delay #(.WIDTH(4 * FW), .DEPTH(FR_DLY)) u_fr_dly (
    .clk (clk),
    .en  (en),
    .din ({f_pbca, f_pbco, f_pcca, f_pcco}),
    .dout(fr_t)
  );

  // entropy terms, log2(total) shared by the three term units
  gme_log2 u_log_n (
    .clk(clk),
    .en (en),
    .x  (s0_n),
    .lg (ln_n)
  );

  gme_plogp #(.COUNT_BITS(COUNT_BITS)) u_term_mar (
    .clk(clk), .en(en), .c(s0_mar), .n(s0_n), .ln(ln_n), .term(tm_mar)
  );
  gme_plogp #(.COUNT_BITS(COUNT_BITS)) u_term_case (
    .clk(clk), .en(en), .c((COUNT_BITS+1)'(s0_ca)), .n(s0_n), .ln(ln_n), .term(tm_ca)
  );
  gme_plogp #(.COUNT_BITS(COUNT_BITS)) u_term_ctrl (
    .clk(clk), .en(en), .c((COUNT_BITS+1)'(s0_co)), .n(s0_n), .ln(ln_n), .term(tm_co)
  );

  gme_delay #(.WIDTH(SB_W), .DEPTH(T)) u_sb_dly (
    .clk (clk),
    .en  (en),
    .din ({s0_cls, s0_last, s0_mism, s0_mar}),
    .dout(sb_t)
  );

  assign {cls_t, last_t, mism_t, mar_t} = sb_t;

  always_ff @(posedge clk) begin
    if (en) begin
      cls1  <= cls_t;
      last1 <= last_t;
      mism1 <= mism_t;
      mar1  <= mar_t;
      fr1   <= fr_t;
      // sums restart on the first class of each item
      if (vpipe[T]) begin
        h_acc  <= ((cls_t == FIRST_CLASS) ? '0 : h_acc) + ACC_W'(tm_mar);
        hy_acc <= ((cls_t == FIRST_CLASS) ? '0 : hy_acc) + ACC_W'(tm_ca)
                + ACC_W'(tm_co);
      end
    end
  end

  assign h_rnd  = {1'b0, h_acc} + RND;
  assign hy_rnd = {1'b0, hy_acc} + RND;

  always_ff @(posedge clk) begin
    if (en) begin
      class_index    <= cls1;
      margin         <= mar1;
      pbc_case       <= fr1[4*FW-1:3*FW];
      pbc_control    <= fr1[3*FW-1:2*FW];
      pca_case       <= fr1[2*FW-1:FW];
      pca_control    <= fr1[FW-1:0];
      entropy        <= last1 ? h_rnd[RSH +: FRAC_BITS+2] : '0;
      joint_entropy  <= last1 ? hy_rnd[RSH +: FRAC_BITS+2] : '0;
      total_mismatch <= mism1;
      last           <= last1;
    end
  end

endmodule

@@ dv/tb_genotype_marginal_entropy.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_genotype_marginal_entropy
// Self-checking bench for the genotype marginal entropy block.
// ----------------------------------------------------------------------------
// A queue of count sets feeds a clocked driver with random gaps. Each accepted
// set is turned into four expected class beats by a bit-exact fixed-point
// model. A clocked monitor with random backpressure compares every output
// beat field by field against the oldest expected beat.
// ----------------------------------------------------------------------------
module tb_genotype_marginal_entropy;
  import gme_pkg::*;

  localparam int CB = DEF_COUNT_BITS;
  localparam int FB = DEF_FRAC_BITS;
  localparam int NRAND = 260;

  typedef struct {
    logic [CB-1:0]         cs [4];
    logic [CB-1:0]         ct [4];
    logic [TOTAL_BITS-1:0] tot;
  } counts_t;

  typedef struct {
    logic [CLASS_W-1:0] cls;
    logic [CB:0]        mar;
    logic [FB:0]        pbc_ca, pbc_co, pca_ca, pca_co;
    logic [FB+1:0]      ent, ent_y;
    logic               mism, lst;
  } beat_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_ready = 0;
  logic [CB-1:0] case_hom_major = 0, case_het = 0, case_hom_minor = 0, case_missing = 0;
  logic [CB-1:0] ctrl_hom_major = 0, ctrl_het = 0, ctrl_hom_minor = 0, ctrl_missing = 0;
  logic [TOTAL_BITS-1:0] total_individuals = 0;
  logic in_ready, out_valid, total_mismatch, last;
  logic [CLASS_W-1:0] class_index;
  logic [CB:0] margin;
  logic [FB:0] pbc_case, pbc_control, pca_case, pca_control;
  logic [FB+1:0] entropy, joint_entropy;

  genotype_marginal_entropy uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  counts_t pending[$];
  beat_t   class_beats[$];
  int      n_sets = 0, n_beats = 0, n_err = 0;
  bit      stim_done = 0;

  function automatic longint unsigned frac_q(longint unsigned num, longint unsigned den);
    longint unsigned q;
    if (num == 0 || den == 0) return 0;
    if (num >= den) return 64'd1 << FB;
    q = ((num << FB) + (den >> 1)) / den;
    return q;
  endfunction

  function automatic longint unsigned log2_fix(longint unsigned x);
    int e;
    longint unsigned m, r;
    e = 0;
    while (e < 30 && (x >> (e + 1)) != 0) e++;
    m = x << (WORK_FRAC - e);
    r = longint'(e) << WORK_FRAC;
    for (int i = 1; i <= WORK_FRAC; i++) begin
      m = (m * m) >> WORK_FRAC;
      if (m >= (64'd2 << WORK_FRAC)) begin
        m >>= 1;
        r |= 64'd1 << (WORK_FRAC - i);
      end
    end
    return r;
  endfunction

  function automatic longint unsigned nlogp_term(longint unsigned c, longint unsigned n);
    longint unsigned d, t;
    if (c == 0 || n == 0 || c >= n) return 0;
    d = log2_fix(n) - log2_fix(c);
    t = (c * d) / n;
    return (t * 64'(LN2_Q30)) >> WORK_FRAC;
  endfunction

  task automatic predict_classes(counts_t s);
    longint unsigned ca[4], co[4], mr[4], ncs, nct, n, h, hy;
    beat_t b;
    ncs = 0; nct = 0; h = 0; hy = 0;
    n = s.tot;
    for (int i = 0; i < 4; i++) begin
      ca[i] = s.cs[i]; co[i] = s.ct[i]; mr[i] = ca[i] + co[i];
      ncs += ca[i]; nct += co[i];
    end
    for (int i = 0; i < 4; i++) begin
      h  += nlogp_term(mr[i], n);
      hy += nlogp_term(ca[i], n) + nlogp_term(co[i], n);
    end
    for (int i = 0; i < 4; i++) begin
      b.cls = CLASS_W'(i);
      b.mar = (CB+1)'(mr[i]);
      b.pbc_ca = (FB+1)'(frac_q(ca[i], ncs));
      b.pbc_co = (FB+1)'(frac_q(co[i], nct));
      b.pca_ca = (FB+1)'(frac_q(ca[i], mr[i]));
      b.pca_co = (FB+1)'(frac_q(co[i], mr[i]));
      b.lst = (i == NUM_CLASSES - 1);
      b.ent   = b.lst ? (FB+2)'((h  + (64'd1 << (WORK_FRAC-FB-1))) >> (WORK_FRAC-FB)) : '0;
      b.ent_y = b.lst ? (FB+2)'((hy + (64'd1 << (WORK_FRAC-FB-1))) >> (WORK_FRAC-FB)) : '0;
      b.mism = (ncs + nct != n);
      class_beats.push_back(b);
    end
  endtask

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    counts_t s;
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_classes(pending.pop_front());
        n_sets++;
        in_gap = $urandom_range(0, 14);
        if ($urandom_range(0, 3) == 0) in_gap = 0;
      end
      if (!in_valid || in_ready) begin
        if (in_gap == 0 && pending.size() > 0) begin
          s = pending[0];
          in_valid <= 1;
          {case_hom_major, case_het, case_hom_minor, case_missing} <=
            {s.cs[0], s.cs[1], s.cs[2], s.cs[3]};
          {ctrl_hom_major, ctrl_het, ctrl_hom_minor, ctrl_missing} <=
            {s.ct[0], s.ct[1], s.ct[2], s.ct[3]};
          total_individuals <= s.tot;
        end else begin
          in_valid <= 0;
          if (in_gap > 0) in_gap--;
        end
      end
    end
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk) begin
    beat_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        n_beats++;
        if (class_beats.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected beat: class %0d", class_index);
        end else begin
          e = class_beats.pop_front();
          if ({class_index, margin, pbc_case, pbc_control, pca_case, pca_control,
               entropy, joint_entropy, total_mismatch, last} !==
              {e.cls, e.mar, e.pbc_ca, e.pbc_co, e.pca_ca, e.pca_co,
               e.ent, e.ent_y, e.mism, e.lst}) begin
            n_err++;
            if (n_err <= 10)
              $display({"mismatch: exp cls %0d mar %0d pbc %0d/%0d pca %0d/%0d ",
                        "ent %0d/%0d mm %0d l %0d | got cls %0d mar %0d ",
                        "pbc %0d/%0d pca %0d/%0d ent %0d/%0d mm %0d l %0d"},
                e.cls, e.mar, e.pbc_ca, e.pbc_co, e.pca_ca, e.pca_co, e.ent, e.ent_y,
                e.mism, e.lst, class_index, margin, pbc_case, pbc_control, pca_case,
                pca_control, entropy, joint_entropy, total_mismatch, last);
          end
        end
        out_gap = $urandom_range(0, 14);
        if ($urandom_range(0, 3) == 0) out_gap = 0;
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  function automatic counts_t make_set(int kind);
    counts_t s;
    longint unsigned sum;
    int sh;
    sum = 0;
    sh = $urandom_range(0, 23);
    for (int i = 0; i < 4; i++) begin
      case (kind)
        0: begin s.cs[i] = CB'($urandom); s.ct[i] = CB'($urandom); end
        1: begin
          s.cs[i] = CB'($urandom >> (8 + sh));
          s.ct[i] = CB'($urandom >> (8 + sh));
        end
        default: begin
          s.cs[i] = ($urandom_range(0, 4) == 0) ? '0 : CB'($urandom >> (8 + sh));
          s.ct[i] = ($urandom_range(0, 4) == 0) ? '0 : CB'($urandom >> (8 + sh));
        end
      endcase
      sum += s.cs[i] + s.ct[i];
    end
    s.tot = TOTAL_BITS'(sum);
    if ($urandom_range(0, 9) == 0) s.tot = TOTAL_BITS'($urandom);
    else if ($urandom_range(0, 19) == 0)
      s.tot = TOTAL_BITS'(sum + $urandom_range(0, 3) - 2);
    return s;
  endfunction

  function automatic counts_t fill_set(logic [CB-1:0] v, logic [TOTAL_BITS-1:0] t);
    counts_t s;
    for (int i = 0; i < 4; i++) begin s.cs[i] = v; s.ct[i] = v; end
    s.tot = t;
    return s;
  endfunction

  initial begin
    counts_t s;
    // directed: zeros, maxima, single nonzero class, saturating terms, mismatch
    pending.push_back(fill_set(0, 0));
    pending.push_back(fill_set('1, 27'(8 * 64'hFFFFFF)));
    pending.push_back(fill_set('1, '1));
    pending.push_back(fill_set(1, 8));
    pending.push_back(fill_set(1, 0));
    pending.push_back(fill_set(5, 3));
    for (int k = 0; k < 8; k++) begin
      s = fill_set(0, 7);
      if (k < 4) s.cs[k] = 7; else s.ct[k-4] = 7;
      pending.push_back(s);
    end
    s = fill_set(0, 10); s.cs[0] = 3; s.cs[1] = 3; s.ct[2] = 4; pending.push_back(s);
    s = fill_set(0, 3);  s.cs[1] = 1; s.ct[1] = 2; pending.push_back(s);
    s = fill_set('1, 27'h5555555); s.ct[3] = 0; pending.push_back(s);
    s = fill_set(24'hAAAAAA, 27'h2AAAAAA); pending.push_back(s);
    for (int k = 0; k < NRAND; k++) pending.push_back(make_set($urandom_range(0, 2)));
    repeat (4) @(posedge clk);
    rst <= 0;
    wait (pending.size() == 0);
    wait (class_beats.size() == 0);
    repeat (PLOGP_LAT + 40) @(posedge clk);
    $display("Checked %0d count sets, %0d class beats, random gaps on both sides.",
             n_sets, n_beats);
    if (n_err == 0 && class_beats.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", n_err);
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("FAIL");
    $finish;
  end

endmodule
